@@ rtl/core/mavg_pkg.sv @@
// Shared constants and types for the moving average window block.
package mavg_pkg;

    localparam int WINDOW_DEPTH_DEFAULT = 64;
    localparam int SAMPLE_W             = 16;
    localparam int FILL_W               = 7;

    typedef struct packed {
        logic full;
        logic empty;
    } mavg_q_status_t;

endpackage

@@ rtl/core/mavg_front.sv @@
// Front end: accepts samples, updates the ring window, running sum and fill count.
module mavg_front #(
    parameter int WINDOW_DEPTH = mavg_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        sample_valid,
    output logic                                        sample_ready,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0]        sample,
    input  mavg_pkg::mavg_q_status_t                    q_status,
    output logic                                        q_push,
    output logic signed [mavg_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] push_sum,
    output logic        [$clog2(WINDOW_DEPTH+1)-1:0]   push_count
);

    localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = mavg_pkg::SAMPLE_W + ADDR_W;

    localparam logic F_IDLE = 1'b0;
    localparam logic F_PUSH = 1'b1;

    logic                                  state_reg;
    logic                                  state_next;
    logic signed [mavg_pkg::SAMPLE_W-1:0]  sample_reg;
    logic        [ADDR_W-1:0]              pos_reg;
    logic        [ADDR_W-1:0]              pos_next;
    logic        [COUNT_W-1:0]             count_reg;
    logic        [COUNT_W-1:0]             count_next;
    logic signed [SUM_W-1:0]               sum_reg;
    logic signed [SUM_W-1:0]               sum_next;
    logic signed [mavg_pkg::SAMPLE_W-1:0]  rd_data_reg;
    logic signed [mavg_pkg::SAMPLE_W-1:0]  leaving;
    logic                                  accept;
    logic                                  full;

    logic [mavg_pkg::SAMPLE_W-1:0] window_mem [WINDOW_DEPTH];

    assign sample_ready = (state_reg == F_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign full         = (count_reg == COUNT_W'(WINDOW_DEPTH));
    assign q_push       = (state_reg == F_PUSH) && !q_status.full;

    // entry under pos_reg is read at accept, overwritten at push
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= window_mem[pos_reg];
        end
        if (q_push)
        begin
            window_mem[pos_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
    end

    always_comb
    begin
        leaving    = full ? rd_data_reg : '0;
        sum_next   = sum_reg + SUM_W'(sample_reg) - SUM_W'(leaving);
        count_next = full ? count_reg : count_reg + 1'b1;
        pos_next   = (pos_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
    end

    assign push_sum   = sum_next;
    assign push_count = count_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (q_push)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pos_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_push)
            begin
                pos_reg   <= pos_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

endmodule

@@ rtl/core/mavg_queue.sv @@
// Two-entry queue between the front end and the divider.
module mavg_queue #(
    parameter int DATA_W = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [DATA_W-1:0]        push_data,
    input  logic                     pop,
    output logic [DATA_W-1:0]        pop_data,
    output mavg_pkg::mavg_q_status_t status
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        level_reg;
    logic [1:0]        level_next;

    assign status.full  = (level_reg == 2'd2);
    assign status.empty = (level_reg == 2'd0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            level_reg <= level_next;
        end
    end

endmodule

@@ rtl/core/mavg_divider.sv @@
// Back end: serial signed division of the running sum by the fill count, output register.
module mavg_divider #(
    parameter int WINDOW_DEPTH = mavg_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  mavg_pkg::mavg_q_status_t                    q_status,
    output logic                                        q_pop,
    input  logic signed [mavg_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] pop_sum,
    input  logic        [$clog2(WINDOW_DEPTH+1)-1:0]   pop_count,
    output logic                                        result_valid,
    input  logic                                        result_ready,
    output logic signed [mavg_pkg::SAMPLE_W-1:0]        average,
    output logic        [mavg_pkg::FILL_W-1:0]          fill_count
);

    localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = mavg_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int STEP_W  = $clog2(SUM_W + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_DONE = 2'd2;

    logic [1:0]                           state_reg;
    logic [1:0]                           state_next;
    logic [STEP_W-1:0]                    step_reg;
    logic [SUM_W-1:0]                     quo_reg;
    logic [COUNT_W-1:0]                   rem_reg;
    logic [COUNT_W-1:0]                   div_reg;
    logic                                 neg_reg;
    logic                                 out_valid_reg;
    logic signed [mavg_pkg::SAMPLE_W-1:0] average_reg;
    logic [mavg_pkg::FILL_W-1:0]          fill_reg;

    logic [SUM_W-1:0]                     mag;
    logic [COUNT_W:0]                     rem_shift;
    logic [COUNT_W:0]                     rem_diff;
    logic                                 qbit;
    logic [mavg_pkg::SAMPLE_W-1:0]        quo16;
    logic [COUNT_W+mavg_pkg::FILL_W-1:0]  count_ext;
    logic                                 load_out;

    assign q_pop    = (state_reg == D_IDLE) && !q_status.empty;
    assign load_out = (state_reg == D_DONE) && (!out_valid_reg || result_ready);

    always_comb
    begin
        mag       = pop_sum[SUM_W-1] ? (~pop_sum + 1'b1) : pop_sum;
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        qbit      = (rem_shift >= {1'b0, div_reg});
        quo16     = quo_reg[mavg_pkg::SAMPLE_W-1:0];
        count_ext = {{mavg_pkg::FILL_W{1'b0}}, div_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                if (load_out)
                begin
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            quo_reg  <= mag;
            rem_reg  <= '0;
            div_reg  <= pop_count;
            neg_reg  <= pop_sum[SUM_W-1];
            step_reg <= STEP_W'(SUM_W - 1);
        end
        else if (state_reg == D_RUN)
        begin
            quo_reg  <= {quo_reg[SUM_W-2:0], qbit};
            rem_reg  <= qbit ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            step_reg <= step_reg - 1'b1;
        end
        if (load_out)
        begin
            average_reg <= neg_reg ? (~quo16 + 1'b1) : quo16;
            fill_reg    <= count_ext[mavg_pkg::FILL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= D_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign average      = average_reg;
    assign fill_count   = fill_reg;

endmodule

@@ rtl/core/moving_average_window.sv @@
// Top level of the moving average window: front end, queue and serial divider.
//
//  channel | valid / ready               | payload
//  --------+-----------------------------+----------------------------------
//  input   | sample_valid / sample_ready | sample (s16)
//  output  | result_valid / result_ready | average (s16), fill_count (u7)
//
// Front end: window read, then update and push; no new request until the push.
// Divider pops again only after the output load; it sets the rate.
// Reset clears sum, count and write pointer; window entries are never cleared.
// Two queue slots and the output register let either side stall independently.
module moving_average_window #(
    parameter int WINDOW_DEPTH = mavg_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [mavg_pkg::SAMPLE_W-1:0] average,
    output logic        [mavg_pkg::FILL_W-1:0]   fill_count
);

    localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = mavg_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int DATA_W  = SUM_W + COUNT_W;

    mavg_pkg::mavg_q_status_t  q_status;
    logic                      q_push;
    logic                      q_pop;
    logic signed [SUM_W-1:0]   push_sum;
    logic        [COUNT_W-1:0] push_count;
    logic        [DATA_W-1:0]  pop_data;

    mavg_front #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .q_status     (q_status),
        .q_push       (q_push),
        .push_sum     (push_sum),
        .push_count   (push_count)
    );

    mavg_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_sum, push_count}),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    mavg_divider #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_pop        (q_pop),
        .pop_sum      (pop_data[DATA_W-1:COUNT_W]),
        .pop_count    (pop_data[COUNT_W-1:0]),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average      (average),
        .fill_count   (fill_count)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue pop while empty");

    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("front end accepted back to back");

    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("divider popped while busy");
`endif

endmodule
